@@ rtl/assert_macros.svh @@
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define CDM_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("demapper check failed");

// Next-cycle implication, disabled while reset is asserted.
`define CDM_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("demapper check failed");

`endif

@@ rtl/cdm_pkg.sv @@
`timescale 1ns / 1ps

package cdm_pkg;

    localparam int POINTS_DEF = 16;
    localparam int PAIR_REGS  = 8;
    localparam int PAIR_W     = 64;
    localparam int ADDR_W     = 6;
    localparam int SAMPLE_W   = 16;
    localparam int DIFF_W     = 17;
    localparam int SQ_W       = 34;
    localparam int DIST_W     = 35;
    localparam int IDX_W      = 4;
    localparam int CNT_W      = 4;
    localparam int BYTE_W     = 8;

    // One item as it travels down the cell chain.
    typedef struct packed {
        logic                       valid;
        logic signed [SAMPLE_W-1:0] si;
        logic signed [SAMPLE_W-1:0] sq;
        logic                       last;
        logic [DIST_W-1:0]          best_d;
        logic [IDX_W-1:0]           best_idx;
    } bus_t;

endpackage

@@ rtl/cdm_apb_regs.sv @@
`timescale 1ns / 1ps

module cdm_apb_regs (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          psel,
    input  logic                                          penable,
    input  logic                                          pwrite,
    input  logic [cdm_pkg::ADDR_W-1:0]                    paddr,
    input  logic [cdm_pkg::PAIR_W-1:0]                    pwdata,
    output logic [cdm_pkg::PAIR_W-1:0]                    prdata,
    output logic                                          pready,
    output logic [cdm_pkg::PAIR_REGS-1:0][cdm_pkg::PAIR_W-1:0] pairs
);

    logic [cdm_pkg::PAIR_REGS-1:0][cdm_pkg::PAIR_W-1:0] pair_reg;
    logic [2:0] sel;

    assign sel    = paddr[cdm_pkg::ADDR_W-1:3];
    assign pready = 1'b1;
    assign prdata = pair_reg[sel];
    assign pairs  = pair_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pair_reg <= '0;
        end
        else if (psel && penable && pwrite)
        begin
            pair_reg[sel] <= pwdata;
        end
    end

endmodule

@@ rtl/cdm_cell.sv @@
`timescale 1ns / 1ps

module cdm_cell #(
    parameter int IDX = 0
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               advance,
    input  logic signed [cdm_pkg::SAMPLE_W-1:0] point_i,
    input  logic signed [cdm_pkg::SAMPLE_W-1:0] point_q,
    input  cdm_pkg::bus_t                      bus_in,
    output cdm_pkg::bus_t                      bus_out
);

    logic signed [cdm_pkg::DIFF_W-1:0] di;
    logic signed [cdm_pkg::DIFF_W-1:0] dq;
    logic signed [cdm_pkg::SQ_W-1:0]   sqi_next;
    logic signed [cdm_pkg::SQ_W-1:0]   sqq_next;
    logic [cdm_pkg::SQ_W-1:0]          sqi_reg;
    logic [cdm_pkg::SQ_W-1:0]          sqq_reg;
    logic [cdm_pkg::DIST_W-1:0]        dist_sum;
    logic                              take;
    cdm_pkg::bus_t                     mid_reg;
    cdm_pkg::bus_t                     out_reg;
    cdm_pkg::bus_t                     out_next;

    // First half: squared component distances.
    assign di       = {bus_in.si[cdm_pkg::SAMPLE_W-1], bus_in.si}
                    - {point_i[cdm_pkg::SAMPLE_W-1], point_i};
    assign dq       = {bus_in.sq[cdm_pkg::SAMPLE_W-1], bus_in.sq}
                    - {point_q[cdm_pkg::SAMPLE_W-1], point_q};
    assign sqi_next = di * di;
    assign sqq_next = dq * dq;

    // Second half: sum and compare, strict less keeps the lower index on a tie.
    assign dist_sum = {1'b0, sqi_reg} + {1'b0, sqq_reg};
    assign take     = (IDX == 0) || (dist_sum < mid_reg.best_d);

    always_comb
    begin
        out_next = mid_reg;
        if (take)
        begin
            out_next.best_d   = dist_sum;
            out_next.best_idx = cdm_pkg::IDX_W'(IDX);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mid_reg <= '0;
            out_reg <= '0;
            sqi_reg <= '0;
            sqq_reg <= '0;
        end
        else if (advance)
        begin
            mid_reg <= bus_in;
            sqi_reg <= sqi_next;
            sqq_reg <= sqq_next;
            out_reg <= out_next;
        end
    end

    assign bus_out = out_reg;

endmodule

@@ rtl/cdm_packer.sv @@
`timescale 1ns / 1ps

module cdm_packer #(
    parameter int SYM_BITS = 4
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       advance,
    input  cdm_pkg::bus_t              bus_in,
    input  logic                       byte_ready,
    output logic                       byte_valid,
    output logic [cdm_pkg::BYTE_W-1:0] packed_byte
);

    localparam int SymsPerByte = cdm_pkg::BYTE_W / SYM_BITS;

    logic [cdm_pkg::BYTE_W-1:0] acc_reg;
    logic [cdm_pkg::BYTE_W-1:0] acc_next;
    logic [cdm_pkg::CNT_W-1:0]  cnt_reg;
    logic [cdm_pkg::CNT_W-1:0]  cnt_next;
    logic [cdm_pkg::CNT_W-1:0]  cnt_inc;
    logic [cdm_pkg::BYTE_W-1:0] merged;
    logic [cdm_pkg::BYTE_W-1:0] sym;
    logic                       full;
    logic                       out_valid_reg;
    logic                       out_valid_next;
    logic [cdm_pkg::BYTE_W-1:0] out_byte_reg;
    logic [cdm_pkg::BYTE_W-1:0] out_byte_next;

    assign sym     = cdm_pkg::BYTE_W'(bus_in.best_idx[SYM_BITS-1:0]);
    assign merged  = acc_reg | cdm_pkg::BYTE_W'(sym << (cnt_reg * SYM_BITS));
    assign cnt_inc = cnt_reg + 1'b1;
    assign full    = cnt_inc >= cdm_pkg::CNT_W'(SymsPerByte);

    always_comb
    begin
        acc_next       = acc_reg;
        cnt_next       = cnt_reg;
        out_byte_next  = out_byte_reg;
        out_valid_next = out_valid_reg && !byte_ready;
        if (advance && bus_in.valid)
        begin
            acc_next = merged;
            cnt_next = cnt_inc;
            if (full)
            begin
                out_byte_next  = merged;
                out_valid_next = 1'b1;
            end
            // A full byte or the end of a buffer both start a fresh byte.
            if (full || bus_in.last)
            begin
                acc_next = '0;
                cnt_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_byte_reg  <= '0;
        end
        else
        begin
            acc_reg       <= acc_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            out_byte_reg  <= out_byte_next;
        end
    end

    assign byte_valid  = out_valid_reg;
    assign packed_byte = out_byte_reg;

endmodule

@@ rtl/constellation_hard_demapper.sv @@
`timescale 1ns / 1ps
// Channel   Handshake                  Payload
// sample    sample_valid/sample_ready  sample_i, sample_q, last_sample
// byte      byte_valid/byte_ready      packed_byte
// config    APB psel/penable/pwrite    paddr, pwdata, prdata, pready
//
// One sample per cycle while no finished byte waits untaken; two register stages per
// point, so a sample passes both stages of every cell before it reaches the packer,
// and a byte it completes is registered in the packer before it shows on byte_valid.
// Reset clears the point registers, the chain valid bits and the packer.
// A waiting byte that is not taken freezes the whole chain and drops
// sample_ready until the byte is taken.

module constellation_hard_demapper #(
    parameter int POINTS = cdm_pkg::POINTS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              sample_valid,
    output logic                              sample_ready,
    input  logic signed [cdm_pkg::SAMPLE_W-1:0] sample_i,
    input  logic signed [cdm_pkg::SAMPLE_W-1:0] sample_q,
    input  logic                              last_sample,
    output logic                              byte_valid,
    input  logic                              byte_ready,
    output logic [cdm_pkg::BYTE_W-1:0]        packed_byte,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [cdm_pkg::ADDR_W-1:0]        paddr,
    input  logic [cdm_pkg::PAIR_W-1:0]        pwdata,
    output logic [cdm_pkg::PAIR_W-1:0]        prdata,
    output logic                              pready
);

    // Clamp the point count to the supported range.
    localparam int NPts    = (POINTS > 16) ? 16 : ((POINTS < 2) ? 2 : POINTS);
    localparam int SymBits = (NPts > 8) ? 4 : ((NPts > 4) ? 3 : ((NPts > 2) ? 2 : 1));

    logic [cdm_pkg::PAIR_REGS-1:0][cdm_pkg::PAIR_W-1:0] pairs;
    cdm_pkg::bus_t chain [NPts+1];
    logic          advance;

    // Move the whole chain unless a finished byte is still waiting.
    assign advance      = !byte_valid || byte_ready;
    assign sample_ready = advance;

    // Head of the chain: the incoming item, with no best distance yet.
    always_comb
    begin
        chain[0]          = '0;
        chain[0].valid    = sample_valid;
        chain[0].si       = sample_i;
        chain[0].sq       = sample_q;
        chain[0].last     = last_sample;
    end

    cdm_apb_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .pairs   (pairs)
    );

    // One cell per point; each compares against its own point and hands the
    // running best on to the next cell.
    for (genvar k = 0; k < NPts; k++)
    begin : g_cell
        localparam int PairIdx = k / 2;
        localparam int Shift   = (k % 2) * 32;

        cdm_cell #(
            .IDX (k)
        ) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .advance (advance),
            .point_i (pairs[PairIdx][Shift +: cdm_pkg::SAMPLE_W]),
            .point_q (pairs[PairIdx][Shift + cdm_pkg::SAMPLE_W +: cdm_pkg::SAMPLE_W]),
            .bus_in  (chain[k]),
            .bus_out (chain[k+1])
        );
    end

    cdm_packer #(
        .SYM_BITS (SymBits)
    ) u_packer (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (advance),
        .bus_in      (chain[NPts]),
        .byte_ready  (byte_ready),
        .byte_valid  (byte_valid),
        .packed_byte (packed_byte)
    );

endmodule

@@ rtl/cdm_checker.sv @@
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cdm_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       sample_ready,
    input logic                       byte_valid,
    input logic                       byte_ready,
    input logic [cdm_pkg::BYTE_W-1:0] packed_byte,
    input logic                       pready
);

    // A waiting byte holds and stays put.
    `CDM_ASSERT_NXT(a_byte_hold, clk, rst_n, byte_valid && !byte_ready, byte_valid)
    `CDM_ASSERT_NXT(a_byte_stable, clk, rst_n, byte_valid && !byte_ready, $stable(packed_byte))
    // Samples stall exactly when a byte waits untaken.
    `CDM_ASSERT_IMP(a_stall_cause, clk, rst_n, !sample_ready, byte_valid && !byte_ready)
    `CDM_ASSERT_IMP(a_stall_when_full, clk, rst_n, byte_valid && !byte_ready, !sample_ready)
    // Register writes never wait.
    `CDM_ASSERT_IMP(a_pready_high, clk, rst_n, 1'b1, pready)

endmodule

bind constellation_hard_demapper cdm_checker u_cdm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .sample_ready (sample_ready),
    .byte_valid   (byte_valid),
    .byte_ready   (byte_ready),
    .packed_byte  (packed_byte),
    .pready       (pready)
);
